// File: design/smb_pkg.sv
// Shared types and constants for the serial-loaded bank mapper.
// Used by smb_regs, smb_map and serial_loaded_bank_mapper_core; no dependencies.
`default_nettype none

package smb_pkg;

    localparam int ADDR_W     = 19;
    localparam int BUS_W      = 16;
    localparam int DATA_W     = 8;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [4:0] SHIFT_INIT     = 5'h10;
    localparam logic [5:0] LARGE_LIMIT    = 6'd16;
    localparam logic [5:0] PRG_BANKS_INIT = 6'd2;
    localparam logic [4:0] HALF_LAST_BANK = 5'd15;

    typedef enum logic [1:0] {
        CMD_CPU_READ  = 2'd0,
        CMD_CPU_WRITE = 2'd1,
        CMD_PPU_READ  = 2'd2,
        CMD_PPU_WRITE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PRG_ROM = 3'd1,
        KIND_PRG_RAM = 3'd2,
        KIND_CHR     = 3'd3,
        KIND_VRAM    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PRG_ROM_BANKS = 2'd0,
        CFG_CHR_IS_ROM    = 2'd1,
        CFG_VERTICAL      = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR_LOW = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG     = 2'd3
    } reg_sel_t;

    typedef enum logic [1:0] {
        MIR_ONE_LOW    = 2'd0,
        MIR_ONE_HIGH   = 2'd1,
        MIR_VERTICAL   = 2'd2,
        MIR_HORIZONTAL = 2'd3
    } mirror_t;

    typedef enum logic [1:0] {
        PRG_FIX_FIRST = 2'd2,
        PRG_FIX_LAST  = 2'd3
    } prg_mode_t;

    typedef struct packed {
        logic [5:0] prg_rom_banks;
        logic       chr_is_rom;
        logic       vertical;
        logic       big_prg;
        logic [4:0] mode_control;
        logic [4:0] chr_low_bank;
        logic [4:0] chr_high_bank;
        logic [4:0] prg_bank_sel;
        logic [1:0] ram_bank_sel;
        logic       upper_half_sel;
    } map_state_t;

    typedef struct packed {
        logic        strobe;
        reg_sel_t    target;
        logic [7:0]  data;
    } ser_wr_t;

endpackage

`default_nettype wire

// File: design/smb_regs.sv
// Configuration registers, serial shift register and bank registers.
// Depends on smb_pkg for the state and write-event types.
`default_nettype none

module smb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [smb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire smb_pkg::ser_wr_t                ser_wr,
    output smb_pkg::map_state_t                  state
);
    import smb_pkg::*;

    map_state_t st_reg;
    map_state_t st_next;
    logic [4:0] shift_reg;
    logic [4:0] shift_next;
    logic [4:0] load_value;
    logic       cfg_hit;

    always_comb
    begin
        st_next    = st_reg;
        shift_next = shift_reg;
        load_value = {ser_wr.data[0], shift_reg[4:1]};
        cfg_hit    = 1'b1;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRG_ROM_BANKS: st_next.prg_rom_banks = cfg_data;
                CFG_CHR_IS_ROM:    st_next.chr_is_rom    = cfg_data[0];
                CFG_VERTICAL:      st_next.vertical      = cfg_data[0];
                default:           cfg_hit               = 1'b0;
            endcase
            if (cfg_hit)
            begin
                shift_next             = SHIFT_INIT;
                st_next.mode_control   = {3'b011, 1'b1, ~st_next.vertical};
                st_next.chr_low_bank   = '0;
                st_next.chr_high_bank  = '0;
                st_next.prg_bank_sel   = '0;
                st_next.ram_bank_sel   = '0;
                st_next.upper_half_sel = 1'b0;
            end
        end
        else if (ser_wr.strobe)
        begin
            if (ser_wr.data[7])
            begin
                shift_next                = SHIFT_INIT;
                st_next.mode_control[3:2] = PRG_FIX_LAST;
            end
            else if (!shift_reg[0])
            begin
                shift_next = load_value;
            end
            else
            begin
                shift_next = SHIFT_INIT;
                case (ser_wr.target)
                    SEL_CONTROL: st_next.mode_control = load_value;
                    SEL_CHR_LOW:
                    begin
                        if (st_reg.big_prg)
                        begin
                            st_next.chr_low_bank   = {4'b0, load_value[0]};
                            st_next.ram_bank_sel   = load_value[3:2];
                            st_next.upper_half_sel = load_value[4];
                        end
                        else
                        begin
                            st_next.chr_low_bank = load_value;
                        end
                    end
                    SEL_CHR_HIGH:
                    begin
                        if (st_reg.big_prg)
                        begin
                            st_next.chr_high_bank  = {4'b0, load_value[0]};
                            st_next.ram_bank_sel   = load_value[3:2];
                            st_next.upper_half_sel = load_value[4];
                        end
                        else
                        begin
                            st_next.chr_high_bank = load_value;
                        end
                    end
                    default: st_next.prg_bank_sel = load_value;
                endcase
            end
        end
        st_next.big_prg = st_next.prg_rom_banks > LARGE_LIMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg                <= SHIFT_INIT;
            st_reg.prg_rom_banks     <= PRG_BANKS_INIT;
            st_reg.chr_is_rom        <= 1'b0;
            st_reg.vertical          <= 1'b0;
            st_reg.big_prg           <= 1'b0;
            st_reg.mode_control      <= 5'b01111;
            st_reg.chr_low_bank      <= '0;
            st_reg.chr_high_bank     <= '0;
            st_reg.prg_bank_sel      <= '0;
            st_reg.ram_bank_sel      <= '0;
            st_reg.upper_half_sel    <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            st_reg    <= st_next;
        end
    end

    assign state = st_reg;

`ifndef SYNTHESIS
    a_cfg_clears_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_hit |=> shift_reg == SHIFT_INIT)
        else $error("Shift register not cleared by a configuration write.");
    a_reset_bit_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ser_wr.strobe && ser_wr.data[7] |=> st_reg.mode_control[3:2] == PRG_FIX_LAST)
        else $error("Reset bit did not force the fixed-last PRG mode.");
    a_small_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.big_prg |-> !st_reg.upper_half_sel && st_reg.ram_bank_sel == 2'd0)
        else $error("Large-variant fields set on a small cartridge.");
`endif

endmodule

`default_nettype wire

// File: design/smb_map.sv
// Address decode and bank mapping for one bus access.
// Depends on smb_pkg; takes the bank state from smb_regs.
`default_nettype none

module smb_map (
    input  wire logic [1:0]                  cmd,
    input  wire logic [smb_pkg::BUS_W-1:0]   bus_address,
    input  wire logic [smb_pkg::DATA_W-1:0]  write_data,
    input  wire smb_pkg::map_state_t         state,
    output smb_pkg::kind_t                   kind,
    output logic [smb_pkg::ADDR_W-1:0]       address,
    output smb_pkg::ser_wr_t                 ser_wr
);
    import smb_pkg::*;

    logic [ADDR_W-1:0] half;
    logic [ADDR_W-1:0] prg_addr;
    logic [ADDR_W-1:0] chr_addr;
    logic [ADDR_W-1:0] vram_addr;
    logic [4:0]        last_bank;
    logic [4:0]        chr_bank;
    logic [13:0]       low14;
    logic              first;
    logic              ram_ok;

    assign half      = {state.upper_half_sel, {(ADDR_W-1){1'b0}}};
    assign last_bank = 5'(state.prg_rom_banks - 6'd1);
    assign low14     = bus_address[13:0];
    assign first     = !bus_address[14];
    assign ram_ok    = (bus_address[15:13] == 3'b011) && !state.prg_bank_sel[4];
    assign chr_bank  = bus_address[12] ? state.chr_high_bank : state.chr_low_bank;

    always_comb
    begin
        case (prg_mode_t'(state.mode_control[3:2]))
            PRG_FIX_LAST:
            begin
                if (first)
                    prg_addr = half + {1'b0, state.prg_bank_sel[3:0], low14};
                else if (state.big_prg)
                    prg_addr = state.upper_half_sel ? {last_bank, low14}
                                                    : {HALF_LAST_BANK, low14};
                else
                    prg_addr = half + {last_bank, low14};
            end
            PRG_FIX_FIRST:
            begin
                if (first)
                    prg_addr = half + {5'b0, low14};
                else
                    prg_addr = half + {1'b0, state.prg_bank_sel[3:0], low14};
            end
            default: prg_addr = half + {1'b0, state.prg_bank_sel[3:1], bus_address[14:0]};
        endcase
    end

    always_comb
    begin
        if (state.mode_control[4])
            chr_addr = {2'b0, chr_bank, bus_address[11:0]};
        else if (state.big_prg)
            chr_addr = {6'b0, bus_address[12:0]};
        else
            chr_addr = {2'b0, state.chr_low_bank[4:1], bus_address[12:0]};
    end

    always_comb
    begin
        case (mirror_t'(state.mode_control[1:0]))
            MIR_VERTICAL:   vram_addr = {8'b0, bus_address[10:0]};
            MIR_HORIZONTAL: vram_addr = {8'b0, bus_address[11], bus_address[9:0]};
            MIR_ONE_LOW:    vram_addr = {9'b0, bus_address[9:0]};
            default:        vram_addr = {8'b0, 1'b1, bus_address[9:0]};
        endcase
    end

    always_comb
    begin
        kind           = KIND_NONE;
        address        = '0;
        ser_wr.strobe  = 1'b0;
        ser_wr.target  = reg_sel_t'(bus_address[14:13]);
        ser_wr.data    = write_data;
        if (!cmd[1])
        begin
            if (bus_address[15])
            begin
                if (cmd_t'(cmd) == CMD_CPU_READ)
                begin
                    kind    = KIND_PRG_ROM;
                    address = prg_addr;
                end
                else
                begin
                    ser_wr.strobe = 1'b1;
                end
            end
            else if (ram_ok)
            begin
                kind    = KIND_PRG_RAM;
                address = {4'b0, state.ram_bank_sel, bus_address[12:0]};
            end
        end
        else if (bus_address[15:13] == 3'b000)
        begin
            if (cmd_t'(cmd) == CMD_PPU_READ || !state.chr_is_rom)
            begin
                kind    = KIND_CHR;
                address = chr_addr;
            end
        end
        else
        begin
            kind    = KIND_VRAM;
            address = vram_addr;
        end
    end

endmodule

`default_nettype wire

// File: design/serial_loaded_bank_mapper_core.sv
// Top level of the serial-loaded bank mapper: handshakes and result register.
// Depends on smb_pkg, smb_regs and smb_map.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle unless a held result waits for out_ready; the single result register sets this figure.
// Reset: rst_n clears all control and bank state to the power-on values at once.
`default_nettype none

module serial_loaded_bank_mapper_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      cmd,
    input  wire logic [smb_pkg::BUS_W-1:0]       bus_address,
    input  wire logic [smb_pkg::DATA_W-1:0]      write_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [2:0]                           access_kind,
    output logic [smb_pkg::ADDR_W-1:0]           mapped_address
);
    import smb_pkg::*;

    map_state_t        state;
    ser_wr_t           map_wr;
    ser_wr_t           ser_wr;
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic              accept;
    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             kind_reg;
    logic [ADDR_W-1:0] address_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        ser_wr        = map_wr;
        ser_wr.strobe = map_wr.strobe && accept;
    end

    smb_map u_map (
        .cmd         (cmd),
        .bus_address (bus_address),
        .write_data  (write_data),
        .state       (state),
        .kind        (kind),
        .address     (address),
        .ser_wr      (map_wr)
    );

    smb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ser_wr    (ser_wr),
        .state     (state)
    );

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            address_reg <= address;
        end
    end

    assign out_valid      = out_valid_reg;
    assign access_kind    = kind_reg;
    assign mapped_address = address_reg;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("Accepted item produced no result.");
    a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg == KIND_NONE |-> address_reg == '0)
        else $error("Result of kind none carries a nonzero address.");
    a_ram_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg == KIND_PRG_RAM |-> address_reg[ADDR_W-1:15] == '0)
        else $error("PRG RAM address beyond 32 KB.");
`endif

endmodule

`default_nettype wire
